>>> rtl/rlmc_pkg.sv
// ----------------------------------------------------------------------------
// rlmc_pkg: shared types and helpers for the run-length-limited cost unit
// Widths, cost types, register indexes and saturating arithmetic used by
// every file of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package rlmc_pkg;

  // Longest run that the state can track, and the cost precision.
  localparam int MAX_RUN    = 32;
  localparam int COST_BITS  = 20;

  // Fixed field widths of the channels.
  localparam int IN_COST_W  = 11;
  localparam int OUT_COST_W = 20;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 2;

  // Derived widths.
  localparam int RUN_IDX_W  = $clog2(MAX_RUN);
  localparam int RUN_LEN_W  = $clog2(MAX_RUN + 1);
  localparam int SUM_W      = COST_BITS + 1;

  typedef logic [COST_BITS-1:0]  cost_t;
  typedef logic [IN_COST_W-1:0]  in_cost_t;
  typedef logic [OUT_COST_W-1:0] out_cost_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [RUN_LEN_W-1:0]  run_len_t;
  typedef logic [SUM_W-1:0]      sum_t;

  typedef cost_t [MAX_RUN-1:0]   cost_arr_t;
  typedef logic [MAX_RUN-1:0]    run_mask_t;

  localparam cost_t     COST_MAX = '1;
  localparam out_cost_t OUT_MAX  = '1;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_RUN = 2'd0,
    REG_MAX_RUN = 2'd1
  } cfg_reg_e;

  // Effective run limits after clamping.
  typedef struct packed {
    run_len_t lo;
    run_len_t hi;
  } run_lim_t;

  // Best entry found by a minimum tree.
  typedef struct packed {
    cost_t cost;
    logic  any;
  } best_t;

  function automatic cost_t sat_add(cost_t a, in_cost_t b);
    sum_t s;
    s = sum_t'(a) + sum_t'(b);
    return (s > sum_t'(COST_MAX)) ? COST_MAX : cost_t'(s);
  endfunction

  function automatic out_cost_t sat_out(cost_t c);
    if (32'(c) > 32'(OUT_MAX)) return OUT_MAX;
    return out_cost_t'(c);
  endfunction

  function automatic run_len_t clamp_run(cfg_data_t v);
    if (v == '0) return run_len_t'(1);
    if (int'(v) > MAX_RUN) return run_len_t'(MAX_RUN);
    return run_len_t'(v);
  endfunction

endpackage

`default_nettype wire

>>> rtl/rlmc_if.sv
// ----------------------------------------------------------------------------
// rlmc_if: channel interfaces of the run-length-limited cost unit
// Column input, result output and configuration write channels, each with a
// valid/ready handshake and a source and a sink modport.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlmc_col_if;
  import rlmc_pkg::*;
  logic     valid;
  logic     ready;
  in_cost_t cost_colour_a;
  in_cost_t cost_colour_b;
  logic     last_column;

  modport source (output valid, output cost_colour_a, output cost_colour_b,
                  output last_column, input ready);
  modport sink   (input valid, input cost_colour_a, input cost_colour_b,
                  input last_column, output ready);
endinterface

interface rlmc_res_if;
  import rlmc_pkg::*;
  logic      valid;
  logic      ready;
  out_cost_t min_cost;
  logic      feasible;

  modport source (output valid, output min_cost, output feasible, input ready);
  modport sink   (input valid, input min_cost, input feasible, output ready);
endinterface

interface rlmc_cfg_if;
  import rlmc_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/run_length_constrained_min_cost_unit.sv
// ----------------------------------------------------------------------------
// run_length_constrained_min_cost_unit: least-cost colouring with run limits
// Columns arrive on col_i, each carrying the cost of colour A and of colour B
// and a flag that marks the last column of a sequence. The unit keeps, for each
// colour and run length, the best cost so far and advances every entry by one
// column per beat. One result beat on res_o follows each last column: the
// least total cost, saturated, and whether any colouring meets the limits.
// cfg_i writes min_run (index 0) and max_run (index 1) and is always ready;
// writes are to be made only while no sequence is in progress; the unit does
// not enforce this. Throughput is one column per cycle while col_i is ready,
// set by the single register stage around the run-cost update and its minimum
// trees. Taking the last column registers the final state and pend_q; the
// result register loads from the trees once free, and the next sequence's first
// column may already be taken. While res_o holds a stalled result, col_i drops
// ready only while another finished sequence waits for the result register.
// Reset returns the limits to 1 and 32 and the unit to the start of a sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module run_length_constrained_min_cost_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  rlmc_col_if.sink   col_i,
  rlmc_res_if.source res_o,
  rlmc_cfg_if.sink   cfg_i
);
  import rlmc_pkg::*;

  // Configuration registers, kept as written and clamped on use.
  cfg_data_t min_run_q, max_run_q;
  run_lim_t  lim;
  run_mask_t sel;

  // Run-cost state and the two minimum trees over it.
  cost_arr_t cost_a, cost_b;
  run_mask_t ok_a, ok_b;
  logic      at_first;
  best_t     best_a, best_b;

  // Control: a finished sequence waiting for the result register, and the
  // result register itself.
  logic      pend_q, pend_d;
  logic      col_acc, res_free, res_load;
  logic      res_valid_q, res_valid_d;
  out_cost_t res_cost_q;
  logic      res_feas_q;
  out_cost_t res_cost;
  logic      res_feas;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_run_q <= cfg_data_t'(1);
      max_run_q <= cfg_data_t'(MAX_RUN);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_MIN_RUN: min_run_q <= cfg_i.data;
        REG_MAX_RUN: max_run_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // When max_run is below min_run the lower bound wins and runs are exact.
  always_comb begin
    lim.lo = clamp_run(min_run_q);
    lim.hi = clamp_run(max_run_q);
    if (lim.hi < lim.lo) lim.hi = lim.lo;
    for (int idx = 0; idx < MAX_RUN; idx++) begin
      sel[idx] = (run_len_t'(idx + 1) >= lim.lo) && (run_len_t'(idx + 1) <= lim.hi);
    end
  end

  rlmc_min_tree u_tree_a (
    .cost_i (cost_a),
    .ok_i   (ok_a),
    .sel_i  (sel),
    .best_o (best_a)
  );

  rlmc_min_tree u_tree_b (
    .cost_i (cost_b),
    .ok_i   (ok_b),
    .sel_i  (sel),
    .best_o (best_b)
  );

  // The state holds the final column of a sequence until the result has been
  // loaded; a first column never reads the old entries, so it may overwrite
  // them in the same cycle.
  assign res_free    = !res_valid_q || res_o.ready;
  assign col_i.ready = !pend_q || res_free;
  assign col_acc     = col_i.valid && col_i.ready;
  assign res_load    = pend_q && res_free;

  rlmc_run_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (col_acc),
    .cost_a_i   (col_i.cost_colour_a),
    .cost_b_i   (col_i.cost_colour_b),
    .last_i     (col_i.last_column),
    .lim_i      (lim),
    .best_a_i   (best_a),
    .best_b_i   (best_b),
    .cost_a_o   (cost_a),
    .cost_b_o   (cost_b),
    .ok_a_o     (ok_a),
    .ok_b_o     (ok_b),
    .at_first_o (at_first)
  );

  // Final answer from the runs that may legally end at the last column.
  always_comb begin
    res_feas = best_a.any || best_b.any;
    res_cost = '0;
    if (best_a.any && best_b.any) begin
      res_cost = sat_out((best_a.cost < best_b.cost) ? best_a.cost : best_b.cost);
    end else if (best_a.any) begin
      res_cost = sat_out(best_a.cost);
    end else if (best_b.any) begin
      res_cost = sat_out(best_b.cost);
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (res_load) pend_d = 1'b0;
    if (col_acc && col_i.last_column) pend_d = 1'b1;
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_cost_q <= res_cost;
      res_feas_q <= res_feas;
    end
  end

  assign res_o.valid    = res_valid_q;
  assign res_o.min_cost = res_cost_q;
  assign res_o.feasible = res_feas_q;

`ifndef NO_ASSERTIONS
  a_res_from_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(pend_q))
    else $error("result appeared without a finished sequence");

  a_infeasible_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_feas_q |-> res_cost_q == '0)
    else $error("infeasible result carries a non-zero cost");

  a_last_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_acc && col_i.last_column |=> at_first && pend_q)
    else $error("last column did not restart the sequence");

  a_mid_column : assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_acc && !col_i.last_column |=> !at_first)
    else $error("column inside a sequence left the start state set");

  a_pend_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && res_valid_q && !res_o.ready |=> pend_q && $stable(ok_a) && $stable(ok_b))
    else $error("final state lost while the result register was full");
`endif

endmodule

`default_nettype wire

>>> rtl/rlmc_min_tree.sv
// ----------------------------------------------------------------------------
// rlmc_min_tree: masked minimum over the run-length entries of one colour
// Balanced compare tree over all entries that are valid and selected.
// ----------------------------------------------------------------------------
`default_nettype none

module rlmc_min_tree (
  input  rlmc_pkg::cost_arr_t cost_i,
  input  rlmc_pkg::run_mask_t ok_i,
  input  rlmc_pkg::run_mask_t sel_i,
  output rlmc_pkg::best_t     best_o
);
  import rlmc_pkg::*;

  localparam int TREE_N = 1 << RUN_IDX_W;

  cost_t node_cost [RUN_IDX_W+1][TREE_N];
  logic  node_ok   [RUN_IDX_W+1][TREE_N];

  always_comb begin
    for (int l = 0; l <= RUN_IDX_W; l++) begin
      for (int i = 0; i < TREE_N; i++) begin
        node_cost[l][i] = '0;
        node_ok[l][i]   = 1'b0;
      end
    end
    for (int i = 0; i < MAX_RUN; i++) begin
      node_cost[0][i] = cost_i[i];
      node_ok[0][i]   = ok_i[i] & sel_i[i];
    end
    // On a tie the lower run length wins; the value is the same either way.
    for (int l = 0; l < RUN_IDX_W; l++) begin
      for (int i = 0; i < TREE_N; i++) begin
        if (i < (TREE_N >> (l + 1))) begin
          if (node_ok[l][2*i] &&
              (!node_ok[l][2*i+1] || (node_cost[l][2*i] <= node_cost[l][2*i+1]))) begin
            node_cost[l+1][i] = node_cost[l][2*i];
          end else begin
            node_cost[l+1][i] = node_cost[l][2*i+1];
          end
          node_ok[l+1][i] = node_ok[l][2*i] | node_ok[l][2*i+1];
        end
      end
    end
  end

  assign best_o.cost = node_cost[RUN_IDX_W][0];
  assign best_o.any  = node_ok[RUN_IDX_W][0];

endmodule

`default_nettype wire

>>> rtl/rlmc_run_state.sv
// ----------------------------------------------------------------------------
// rlmc_run_state: per-colour, per-run-length cost registers
// Holds the best cost for each colour and current run length and advances
// all entries by one column on every accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module rlmc_run_state (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                upd_i,
  input  rlmc_pkg::in_cost_t  cost_a_i,
  input  rlmc_pkg::in_cost_t  cost_b_i,
  input  logic                last_i,
  input  rlmc_pkg::run_lim_t  lim_i,
  input  rlmc_pkg::best_t     best_a_i,
  input  rlmc_pkg::best_t     best_b_i,
  output rlmc_pkg::cost_arr_t cost_a_o,
  output rlmc_pkg::cost_arr_t cost_b_o,
  output rlmc_pkg::run_mask_t ok_a_o,
  output rlmc_pkg::run_mask_t ok_b_o,
  output logic                at_first_o
);
  import rlmc_pkg::*;

  cost_arr_t cost_a_q, cost_a_d, cost_b_q, cost_b_d;
  run_mask_t ok_a_q, ok_a_d, ok_b_q, ok_b_d;
  logic      at_first_q, at_first_d;

  always_comb begin
    cost_a_d   = cost_a_q;
    cost_b_d   = cost_b_q;
    ok_a_d     = ok_a_q;
    ok_b_d     = ok_b_q;
    at_first_d = at_first_q;
    if (upd_i) begin
      at_first_d = last_i;
      if (at_first_q) begin
        ok_a_d      = '0;
        ok_b_d      = '0;
        ok_a_d[0]   = 1'b1;
        ok_b_d[0]   = 1'b1;
        cost_a_d[0] = sat_add('0, cost_a_i);
        cost_b_d[0] = sat_add('0, cost_b_i);
      end else begin
        // A new run of one colour starts from the best finished run of the other.
        ok_a_d[0]   = best_b_i.any;
        cost_a_d[0] = sat_add(best_b_i.cost, cost_a_i);
        ok_b_d[0]   = best_a_i.any;
        cost_b_d[0] = sat_add(best_a_i.cost, cost_b_i);
        for (int idx = 1; idx < MAX_RUN; idx++) begin
          ok_a_d[idx]   = (run_len_t'(idx) < lim_i.hi) && ok_a_q[idx-1];
          cost_a_d[idx] = sat_add(cost_a_q[idx-1], cost_a_i);
          ok_b_d[idx]   = (run_len_t'(idx) < lim_i.hi) && ok_b_q[idx-1];
          cost_b_d[idx] = sat_add(cost_b_q[idx-1], cost_b_i);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_a_q     <= '0;
      ok_b_q     <= '0;
      at_first_q <= 1'b1;
    end else begin
      ok_a_q     <= ok_a_d;
      ok_b_q     <= ok_b_d;
      at_first_q <= at_first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cost_a_q <= cost_a_d;
    cost_b_q <= cost_b_d;
  end

  assign cost_a_o   = cost_a_q;
  assign cost_b_o   = cost_b_q;
  assign ok_a_o     = ok_a_q;
  assign ok_b_o     = ok_b_q;
  assign at_first_o = at_first_q;

endmodule

`default_nettype wire
